// ===== src/sfbc_pkg.sv =====
package sfbc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int LAYER_CNT    = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
  } cplx_t;

  // one queued symbol group, tagged with the mode it was accepted under
  typedef struct packed {
    cplx_t [LAYER_CNT-1:0] layer;
    logic                  block_end;
    logic                  four_port;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // subcarrier index within one item's run
  typedef logic [1:0] sub_t;

  localparam sub_t LAST_SUB_TWO  = 2'd1;
  localparam sub_t LAST_SUB_FOUR = 2'd3;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  function automatic sample_t sat_neg(sample_t x);
    sample_t r;
    if (x == SAMPLE_MIN) begin
      r = SAMPLE_MAX;
    end else begin
      r = -x;
    end
    return r;
  endfunction

endpackage

// ===== src/sfbc_if.sv =====
interface sfbc_in_if;
  import sfbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t layer0_re;
  sample_t layer0_im;
  sample_t layer1_re;
  sample_t layer1_im;
  sample_t layer2_re;
  sample_t layer2_im;
  sample_t layer3_re;
  sample_t layer3_im;
  logic    block_end;

  modport source (
    output valid, layer0_re, layer0_im, layer1_re, layer1_im,
           layer2_re, layer2_im, layer3_re, layer3_im, block_end,
    input  ready
  );

  modport sink (
    input  valid, layer0_re, layer0_im, layer1_re, layer1_im,
           layer2_re, layer2_im, layer3_re, layer3_im, block_end,
    output ready
  );
endinterface

interface sfbc_out_if;
  import sfbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t port0_re;
  sample_t port0_im;
  sample_t port1_re;
  sample_t port1_im;
  sample_t port2_re;
  sample_t port2_im;
  sample_t port3_re;
  sample_t port3_im;
  logic    run_last;
  logic    block_last;

  modport source (
    output valid, port0_re, port0_im, port1_re, port1_im,
           port2_re, port2_im, port3_re, port3_im, run_last, block_last,
    input  ready
  );

  modport sink (
    input  valid, port0_re, port0_im, port1_re, port1_im,
           port2_re, port2_im, port3_re, port3_im, run_last, block_last,
    output ready
  );
endinterface

// ===== src/sfbc_transmit_diversity_precoder_top.sv =====
// Alamouti space-frequency block code precoder. Each accepted transaction on
// in_ch holds one symbol per layer and produces two subcarrier results in
// two-port mode or four in four-port mode, one result per clock on out_ch
// while out_ch.ready holds, the first one after the queue entry and the output
// register; run_last marks the last result of a run and block_last that result
// for an input flagged block_end. The single output register issues one
// subcarrier per cycle unless out_ch.ready stalls it. A two-entry queue
// sits between the input side and the output sequencer, so input is taken
// while results wait. The mode applies to items accepted after the write.
module sfbc_transmit_diversity_precoder_top (
  input  logic         clk,
  input  logic         rst_n,
  sfbc_in_if.sink      in_ch,
  sfbc_out_if.source   out_ch,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);
  import sfbc_pkg::*;

  q_status_t q_status;
  logic      push;
  logic      pop;
  item_t     push_item;
  item_t     head_item;

  sfbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  sfbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_status  (q_status)
  );

  sfbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_status  (q_status),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/sfbc_front.sv =====
module sfbc_front (
  input  logic                clk,
  input  logic                rst_n,
  sfbc_in_if.sink             in_ch,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  sfbc_pkg::q_status_t q_status,
  output logic                push,
  output sfbc_pkg::item_t     push_item
);
  import sfbc_pkg::*;

  logic four_port_mode_r;
  logic four_port_mode_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    four_port_mode_nxt = four_port_mode_r;
    if (cfg_valid) begin
      four_port_mode_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_port_mode_r <= 1'b0;
    end else begin
      four_port_mode_r <= four_port_mode_nxt;
    end
  end

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  always_comb begin
    push_item.layer[0].re = in_ch.layer0_re;
    push_item.layer[0].im = in_ch.layer0_im;
    push_item.layer[1].re = in_ch.layer1_re;
    push_item.layer[1].im = in_ch.layer1_im;
    push_item.layer[2].re = in_ch.layer2_re;
    push_item.layer[2].im = in_ch.layer2_im;
    push_item.layer[3].re = in_ch.layer3_re;
    push_item.layer[3].im = in_ch.layer3_im;
    push_item.block_end   = in_ch.block_end;
    push_item.four_port   = four_port_mode_r;
  end

endmodule

// ===== src/sfbc_queue.sv =====
module sfbc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfbc_pkg::item_t     push_item,
  input  logic                pop,
  output sfbc_pkg::item_t     head_item,
  output sfbc_pkg::q_status_t q_status
);
  import sfbc_pkg::*;

  item_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_item      = entry_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
    end
    if (pop) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/sfbc_back.sv =====
module sfbc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sfbc_pkg::item_t     head_item,
  input  sfbc_pkg::q_status_t q_status,
  output logic                pop,
  sfbc_out_if.source          out_ch
);
  import sfbc_pkg::*;

  sub_t    sub_r;
  sub_t    sub_nxt;
  sub_t    last_sub;
  logic    issue;
  logic    out_valid_r;
  logic    out_valid_nxt;
  cplx_t   sym_a;
  cplx_t   sym_b;
  cplx_t   first_c;
  cplx_t   second_c;
  cplx_t   port_c [LAYER_CNT];
  cplx_t   port_r [LAYER_CNT];
  logic    run_last_r;
  logic    block_last_r;
  logic    run_last_c;

  assign last_sub   = head_item.four_port ? LAST_SUB_FOUR : LAST_SUB_TWO;
  assign issue      = !q_status.empty && (!out_valid_r || out_ch.ready);
  assign run_last_c = (sub_r == last_sub);
  assign pop        = issue && run_last_c;

  // upper half of a four-port run codes the x2/x3 pair
  always_comb begin
    sym_a = sub_r[1] ? head_item.layer[2] : head_item.layer[0];
    sym_b = sub_r[1] ? head_item.layer[3] : head_item.layer[1];
    if (sub_r[0]) begin
      first_c     = sym_b;
      second_c.re = sym_a.re;
      second_c.im = sat_neg(sym_a.im);
    end else begin
      first_c     = sym_a;
      second_c.re = sat_neg(sym_b.re);
      second_c.im = sym_b.im;
    end
  end

  always_comb begin
    for (int p = 0; p < LAYER_CNT; p++) begin
      port_c[p] = '0;
    end
    priority if (!head_item.four_port) begin
      port_c[0] = first_c;
      port_c[1] = second_c;
    end else if (!sub_r[1]) begin
      port_c[0] = first_c;
      port_c[2] = second_c;
    end else begin
      port_c[1] = first_c;
      port_c[3] = second_c;
    end
  end

  always_comb begin
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
      sub_nxt       = run_last_c ? '0 : sub_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int p = 0; p < LAYER_CNT; p++) begin
        port_r[p] <= port_c[p];
      end
      run_last_r   <= run_last_c;
      block_last_r <= run_last_c && head_item.block_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.port0_re   = port_r[0].re;
  assign out_ch.port0_im   = port_r[0].im;
  assign out_ch.port1_re   = port_r[1].re;
  assign out_ch.port1_im   = port_r[1].im;
  assign out_ch.port2_re   = port_r[2].re;
  assign out_ch.port2_im   = port_r[2].im;
  assign out_ch.port3_re   = port_r[3].re;
  assign out_ch.port3_im   = port_r[3].im;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.block_last = block_last_r;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfbc_pkg::*;

  typedef struct {
    sample_t re [4];
    sample_t im [4];
    logic    block_end;
  } symbol_group_t;

  typedef struct {
    sample_t re [4];
    sample_t im [4];
    logic    run_last;
    logic    block_last;
  } subcarrier_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  sfbc_in_if  in_ch ();
  sfbc_out_if out_ch ();

  sfbc_transmit_diversity_precoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // local copy of the mode register
  bit four_port_mode = 1'b0;
  bit gaps_off = 1'b0;
  int stall_left = 0;
  int bad_results = 0;
  subcarrier_t pending_subcarriers [$];

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[sfbc_transmit_diversity_precoder_top] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return sample_t'(SAMPLE_MIN + 1);
      3: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic symbol_group_t random_group();
    symbol_group_t g;
    for (int i = 0; i < 4; i++) begin
      g.re[i] = pick_sample();
      g.im[i] = pick_sample();
    end
    g.block_end = ($urandom_range(0, 3) == 0);
    return g;
  endfunction

  // corner-case symbol groups shared by both directed tests
  function automatic symbol_group_t corner_group(int kind);
    symbol_group_t g;
    g = random_group();
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: begin g.re[i] = '0;                      g.im[i] = '0;                      end
        1: begin g.re[i] = SAMPLE_MAX;              g.im[i] = SAMPLE_MAX;              end
        2: begin g.re[i] = SAMPLE_MIN;              g.im[i] = SAMPLE_MIN;              end
        3: begin g.re[i] = sample_t'(SAMPLE_MIN + 1); g.im[i] = sample_t'(SAMPLE_MIN + 1); end
        4: begin g.re[i] = -16'sd1;                 g.im[i] = -16'sd1;                 end
        5: begin
          g.re[i] = sample_t'(1000 * (i + 1));
          g.im[i] = sample_t'(-1000 * (i + 1) - 7);
        end
        6: begin g.re[i] = SAMPLE_MIN;              g.im[i] = SAMPLE_MAX;              end
        7: begin g.re[i] = SAMPLE_MAX;              g.im[i] = SAMPLE_MIN;              end
        8: begin
          if (i % 2 == 0) begin
            g.re[i] = SAMPLE_MIN;
            g.im[i] = SAMPLE_MIN;
          end
        end
        default: ;
      endcase
    end
    g.block_end = kind[0];
    return g;
  endfunction

  function automatic sample_t neg_clip(sample_t x);
    return (x == SAMPLE_MIN) ? SAMPLE_MAX : sample_t'(-x);
  endfunction

  function automatic void alamouti_pair(inout subcarrier_t first, inout subcarrier_t second,
                                        input int pa, input int pb,
                                        input sample_t ar, input sample_t ai,
                                        input sample_t br, input sample_t bi);
    first.re[pa]  = ar;
    first.im[pa]  = ai;
    first.re[pb]  = neg_clip(br);
    first.im[pb]  = bi;
    second.re[pa] = br;
    second.im[pa] = bi;
    second.re[pb] = ar;
    second.im[pb] = neg_clip(ai);
  endfunction

  function automatic void precode_group(symbol_group_t g);
    subcarrier_t sc [4];
    int n;
    n = four_port_mode ? 4 : 2;
    for (int k = 0; k < 4; k++) begin
      for (int p = 0; p < 4; p++) begin
        sc[k].re[p] = '0;
        sc[k].im[p] = '0;
      end
      sc[k].run_last   = 1'b0;
      sc[k].block_last = 1'b0;
    end
    if (n == 2) begin
      alamouti_pair(sc[0], sc[1], 0, 1, g.re[0], g.im[0], g.re[1], g.im[1]);
    end else begin
      alamouti_pair(sc[0], sc[1], 0, 2, g.re[0], g.im[0], g.re[1], g.im[1]);
      alamouti_pair(sc[2], sc[3], 1, 3, g.re[2], g.im[2], g.re[3], g.im[3]);
    end
    sc[n-1].run_last   = 1'b1;
    sc[n-1].block_last = g.block_end;
    for (int k = 0; k < n; k++) begin
      pending_subcarriers.insert(pending_subcarriers.size(), sc[k]);
    end
  endfunction

  function automatic string show(subcarrier_t s);
    return $sformatf("p0=(%0d,%0d) p1=(%0d,%0d) p2=(%0d,%0d) p3=(%0d,%0d) rl=%0b bl=%0b",
                     s.re[0], s.im[0], s.re[1], s.im[1], s.re[2], s.im[2],
                     s.re[3], s.im[3], s.run_last, s.block_last);
  endfunction

  task automatic send_group(symbol_group_t g);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.layer0_re <= g.re[0];
    in_ch.layer0_im <= g.im[0];
    in_ch.layer1_re <= g.re[1];
    in_ch.layer1_im <= g.im[1];
    in_ch.layer2_re <= g.re[2];
    in_ch.layer2_im <= g.im[2];
    in_ch.layer3_re <= g.re[3];
    in_ch.layer3_im <= g.im[3];
    in_ch.block_end <= g.block_end;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    precode_group(g);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_subcarriers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(bit four_port);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= four_port;
    do @(posedge clk); while (!cfg_ready);
    four_port_mode = four_port;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mode out of reset is two-port, so no write here
  task automatic test_two_port_directed();
    for (int k = 0; k < 10; k++) begin
      send_group(corner_group(k));
    end
  endtask

  task automatic test_four_port_directed();
    write_mode(1'b1);
    for (int k = 0; k < 10; k++) begin
      send_group(corner_group(k));
    end
  endtask

  task automatic test_random_two_port();
    write_mode(1'b0);
    for (int n = 0; n < 120; n++) begin
      if (n % 40 == 39) begin
        wait_drained();
      end
      send_group(random_group());
    end
  endtask

  task automatic test_random_four_port();
    write_mode(1'b1);
    // gap-free input stretch first, then random idling
    gaps_off = 1'b1;
    for (int n = 0; n < 120; n++) begin
      if (n == 40) begin
        gaps_off = 1'b0;
      end
      send_group(random_group());
    end
  endtask

  task automatic test_mode_changes();
    bit modes [6] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    int count;
    foreach (modes[ph]) begin
      write_mode(modes[ph]);
      count = $urandom_range(10, 30);
      for (int n = 0; n < count; n++) begin
        send_group(random_group());
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    subcarrier_t got;
    subcarrier_t want;
    bit bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.re[0] = out_ch.port0_re;
      got.im[0] = out_ch.port0_im;
      got.re[1] = out_ch.port1_re;
      got.im[1] = out_ch.port1_im;
      got.re[2] = out_ch.port2_re;
      got.im[2] = out_ch.port2_im;
      got.re[3] = out_ch.port3_re;
      got.im[3] = out_ch.port3_im;
      got.run_last   = out_ch.run_last;
      got.block_last = out_ch.block_last;
      if (pending_subcarriers.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("unexpected subcarrier transaction: %s", show(got));
        end
      end else begin
        want = pending_subcarriers.pop_front();
        bad = (got.run_last !== want.run_last) || (got.block_last !== want.block_last);
        for (int p = 0; p < 4; p++) begin
          if (got.re[p] !== want.re[p] || got.im[p] !== want.im[p]) begin
            bad = 1'b1;
          end
        end
        if (bad) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("subcarrier mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  initial begin
    int drain_wait;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = 1'b0;
    out_ch.ready    = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.layer0_re = '0;
    in_ch.layer0_im = '0;
    in_ch.layer1_re = '0;
    in_ch.layer1_im = '0;
    in_ch.layer2_re = '0;
    in_ch.layer2_im = '0;
    in_ch.layer3_re = '0;
    in_ch.layer3_im = '0;
    in_ch.block_end = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_two_port_directed();
    test_four_port_directed();
    test_random_two_port();
    test_random_four_port();
    test_mode_changes();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (pending_subcarriers.size() != 0 && drain_wait < 2000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (pending_subcarriers.size() != 0) begin
      bad_results += pending_subcarriers.size();
      $display("%0d subcarrier results never arrived", pending_subcarriers.size());
    end
    if (bad_results == 0) begin
      $display("[sfbc_transmit_diversity_precoder_top] OK");
    end else begin
      $display("[sfbc_transmit_diversity_precoder_top] ERROR");
    end
    $finish;
  end

endmodule
